>>> rtl/small_cell_velocity_correction_assert.svh
// Assertion macros shared by the small-cell velocity correction RTL.
`ifndef SMALL_CELL_VELOCITY_CORRECTION_ASSERT_SVH
`define SMALL_CELL_VELOCITY_CORRECTION_ASSERT_SVH

// Same-cycle implication, held off during reset.
`define SCVC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("scvc: same-cycle check failed");

// Next-cycle implication, held off during reset.
`define SCVC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("scvc: next-cycle check failed");

`endif

>>> rtl/scvc_pkg.sv
`timescale 1ns / 1ps
// Shared constants and types for the small-cell velocity correction block.
package scvc_pkg;

  localparam int VEL_WIDTH_DEF = 24;
  localparam int FRAC_BITS_DEF = 16;
  localparam int QUEUE_DEPTH   = 4;

  localparam logic [1:0] AXIS_X = 2'd0;
  localparam logic [1:0] AXIS_Y = 2'd1;

  localparam logic CFG_THRESHOLD = 1'b0;
  localparam logic CFG_WALL_MODE = 1'b1;

  typedef struct packed {
    logic corrected;
    logic use_div;
  } cls_t;

  localparam int CLS_WIDTH = $bits(cls_t);

endpackage

>>> rtl/scvc_front.sv
`timescale 1ns / 1ps
// Front end: classifies an incoming cell and works out the non-divide result.
module scvc_front #(
  parameter int VEL_WIDTH = scvc_pkg::VEL_WIDTH_DEF,
  parameter int FRAC_BITS = scvc_pkg::FRAC_BITS_DEF
) (
  input  logic [1:0]                  axis,
  input  logic [FRAC_BITS:0]          volume_fraction,
  input  logic [FRAC_BITS:0]          area_low,
  input  logic [FRAC_BITS:0]          area_high,
  input  logic signed [VEL_WIDTH-1:0] old_velocity,
  input  logic signed [VEL_WIDTH-1:0] wall_vel_x,
  input  logic signed [VEL_WIDTH-1:0] wall_vel_y,
  input  logic signed [VEL_WIDTH-1:0] wall_vel_z,
  input  logic [FRAC_BITS:0]          threshold,
  input  logic                        wall_mode,
  output scvc_pkg::cls_t              cls,
  output logic [VEL_WIDTH-1:0]        byp_vel
);
  import scvc_pkg::*;

  logic                        in_range;
  logic                        zero_area;
  logic                        moving;
  logic signed [VEL_WIDTH-1:0] wall;
  logic signed [VEL_WIDTH-1:0] clamp_val;

  always_comb begin
    case (axis)
      AXIS_X:  wall = wall_vel_x;
      AXIS_Y:  wall = wall_vel_y;
      default: wall = wall_vel_z;
    endcase
  end

  assign in_range  = (volume_fraction != '0) && (volume_fraction < threshold);
  assign zero_area = (area_low == '0) && (area_high == '0);
  assign moving    = wall_mode && (wall != '0);

  // negative wall: max(old, wall); positive wall: min(old, wall)
  always_comb begin
    if (wall[VEL_WIDTH-1]) begin
      clamp_val = (old_velocity > wall) ? old_velocity : wall;
    end else begin
      clamp_val = (old_velocity < wall) ? old_velocity : wall;
    end
  end

  always_comb begin
    cls.corrected = in_range;
    cls.use_div   = in_range && !moving && !zero_area;
    if (!in_range) begin
      byp_vel = old_velocity;
    end else if (moving) begin
      byp_vel = clamp_val;
    end else if (zero_area) begin
      byp_vel = '0;
    end else begin
      byp_vel = old_velocity;
    end
  end

endmodule

>>> rtl/scvc_queue.sv
`timescale 1ns / 1ps
// Short FIFO between the classifying front end and the divide back end.
`include "small_cell_velocity_correction_assert.svh"
module scvc_queue #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);
  import scvc_pkg::*;

  localparam int DEPTH = QUEUE_DEPTH;
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] cnt_r;
  logic [CNT_W-1:0] cnt_nxt;
  logic             wr_en;
  logic             rd_en;

  assign full  = (cnt_r == CNT_W'(DEPTH));
  assign empty = (cnt_r == '0);
  assign wr_en = push && !full;
  assign rd_en = pop && !empty;
  assign rdata = mem_r[rd_ptr_r];

  always_comb begin
    case ({wr_en, rd_en})
      2'b10:   cnt_nxt = cnt_r + 1'b1;
      2'b01:   cnt_nxt = cnt_r - 1'b1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (wr_en) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (rd_en) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

  `SCVC_ASSERT_NOW(a_cnt_bound, clk, rst_n, 1'b1, cnt_r <= CNT_W'(DEPTH))
  `SCVC_ASSERT_NEXT(a_cnt_inc, clk, rst_n, wr_en && !rd_en, cnt_r == $past(cnt_r) + 1'b1)
  `SCVC_ASSERT_NEXT(a_cnt_dec, clk, rst_n, rd_en && !wr_en, cnt_r == $past(cnt_r) - 1'b1)

endmodule

>>> rtl/scvc_back.sv
`timescale 1ns / 1ps
// Back end: split multiply, sum, bit-per-stage restoring divide and final select.
`include "small_cell_velocity_correction_assert.svh"
module scvc_back #(
  parameter int VEL_WIDTH = scvc_pkg::VEL_WIDTH_DEF,
  parameter int FRAC_BITS = scvc_pkg::FRAC_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  input  scvc_pkg::cls_t              in_cls,
  input  logic [FRAC_BITS:0]          in_area_low,
  input  logic [FRAC_BITS:0]          in_area_high,
  input  logic [VEL_WIDTH-1:0]        in_face_vel_low,
  input  logic [VEL_WIDTH-1:0]        in_face_vel_high,
  input  logic [VEL_WIDTH-1:0]        in_byp_vel,
  output logic                        in_pop,
  output logic                        out_empty,
  input  logic                        out_pop,
  output logic signed [VEL_WIDTH-1:0] out_new_velocity,
  output logic                        out_corrected
);
  import scvc_pkg::*;

  localparam int FW   = FRAC_BITS + 1;
  localparam int DW   = FW + 1;
  localparam int LO_W = (VEL_WIDTH + 1) / 2;
  localparam int HI_W = VEL_WIDTH - LO_W;
  localparam int NW   = VEL_WIDTH + DW;
  localparam int PL_W = FW + LO_W;
  localparam int PH_W = FW + HI_W;

  logic adv;

  // multiply stage
  logic                 s1_v_r;
  logic [PL_W-1:0]      pal_lo_r, pah_lo_r;
  logic [PH_W-1:0]      pal_hi_r, pah_hi_r;
  logic [DW-1:0]        s1_d_r;
  cls_t                 s1_cls_r;
  logic [VEL_WIDTH-1:0] s1_byp_r;
  logic [VEL_WIDTH-1:0] off_l, off_h;

  // divide stages; index 0 holds the summed numerator
  logic [VEL_WIDTH:0]   v_r;
  logic [DW-1:0]        rem_r [0:VEL_WIDTH];
  logic [VEL_WIDTH-1:0] sh_r  [0:VEL_WIDTH];
  logic [DW-1:0]        d_r   [0:VEL_WIDTH];
  cls_t                 cls_r [0:VEL_WIDTH];
  logic [VEL_WIDTH-1:0] byp_r [0:VEL_WIDTH];
  logic [DW:0]          trial [1:VEL_WIDTH];
  logic                 take  [1:VEL_WIDTH];
  logic [DW-1:0]        rem_nxt [1:VEL_WIDTH];
  logic [NW-1:0]        hi_sum, num;

  // output stage
  logic                 out_v_r;
  logic [VEL_WIDTH-1:0] out_vel_r, out_vel_nxt;
  logic                 out_corr_r;
  logic [VEL_WIDTH-1:0] q_s, q_fin;
  logic                 fix;

  assign adv    = !out_v_r || out_pop;
  assign in_pop = adv && in_valid;

  // offset binary: flip the sign bit so the products stay unsigned
  assign off_l = in_face_vel_low  ^ {1'b1, {(VEL_WIDTH-1){1'b0}}};
  assign off_h = in_face_vel_high ^ {1'b1, {(VEL_WIDTH-1){1'b0}}};

  always_ff @(posedge clk) begin
    if (adv) begin
      pal_lo_r <= PL_W'(in_area_low)  * PL_W'(off_l[LO_W-1:0]);
      pah_lo_r <= PL_W'(in_area_high) * PL_W'(off_h[LO_W-1:0]);
      pal_hi_r <= PH_W'(in_area_low)  * PH_W'(off_l[VEL_WIDTH-1:LO_W]);
      pah_hi_r <= PH_W'(in_area_high) * PH_W'(off_h[VEL_WIDTH-1:LO_W]);
      s1_d_r   <= DW'(in_area_low) + DW'(in_area_high);
      s1_cls_r <= in_cls;
      s1_byp_r <= in_byp_vel;
    end
  end

  assign hi_sum = NW'(pal_hi_r) + NW'(pah_hi_r);
  assign num    = (hi_sum << LO_W) + NW'(pal_lo_r) + NW'(pah_lo_r);

  always_comb begin
    for (int k = 1; k <= VEL_WIDTH; k++) begin
      trial[k]   = {rem_r[k-1], sh_r[k-1][VEL_WIDTH-1]};
      take[k]    = (trial[k] >= {1'b0, d_r[k-1]});
      rem_nxt[k] = take[k] ? DW'(trial[k] - {1'b0, d_r[k-1]}) : trial[k][DW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      // top bits of the numerator are below the divisor: start remainder
      rem_r[0] <= num[NW-1:VEL_WIDTH];
      sh_r[0]  <= num[VEL_WIDTH-1:0];
      d_r[0]   <= s1_d_r;
      cls_r[0] <= s1_cls_r;
      byp_r[0] <= s1_byp_r;
      for (int k = 1; k <= VEL_WIDTH; k++) begin
        rem_r[k] <= rem_nxt[k];
        sh_r[k]  <= {sh_r[k-1][VEL_WIDTH-2:0], take[k]};
        d_r[k]   <= d_r[k-1];
        cls_r[k] <= cls_r[k-1];
        byp_r[k] <= byp_r[k-1];
      end
    end
  end

  // unbias the quotient, then round a negative floor back toward zero
  assign q_s   = {~sh_r[VEL_WIDTH][VEL_WIDTH-1], sh_r[VEL_WIDTH][VEL_WIDTH-2:0]};
  assign fix   = q_s[VEL_WIDTH-1] && (rem_r[VEL_WIDTH] != '0);
  assign q_fin = q_s + VEL_WIDTH'(fix);
  assign out_vel_nxt = cls_r[VEL_WIDTH].use_div ? q_fin : byp_r[VEL_WIDTH];

  always_ff @(posedge clk) begin
    if (adv) begin
      out_vel_r  <= out_vel_nxt;
      out_corr_r <= cls_r[VEL_WIDTH].corrected;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      v_r     <= '0;
      out_v_r <= 1'b0;
    end else if (adv) begin
      s1_v_r  <= in_valid;
      v_r     <= {v_r[VEL_WIDTH-1:0], s1_v_r};
      out_v_r <= v_r[VEL_WIDTH];
    end
  end

  assign out_empty        = !out_v_r;
  assign out_new_velocity = out_vel_r;
  assign out_corrected    = out_corr_r;

  `SCVC_ASSERT_NEXT(a_hold_on_stall, clk, rst_n, !adv, $stable(v_r) && $stable(s1_v_r))
  `SCVC_ASSERT_NOW(a_rem_below_div, clk, rst_n, v_r[VEL_WIDTH] && cls_r[VEL_WIDTH].use_div, rem_r[VEL_WIDTH] < d_r[VEL_WIDTH])
  `SCVC_ASSERT_NOW(a_div_only_small, clk, rst_n, in_valid && in_cls.use_div, in_cls.corrected)

endmodule

>>> rtl/small_cell_velocity_correction.sv
`timescale 1ns / 1ps
// Top level of the small-cell velocity correction block.
//
// Input channel: queue-style push/full. A beat (one cell, one axis) is taken
// on a rising edge with push high and full low. Result channel: empty/pop;
// the oldest result sits on out_new_velocity/out_corrected while empty is low
// and is taken on an edge with pop high. Config: cfg_valid/cfg_ready with
// cfg_index (0 threshold, 1 wall-flow mode) and cfg_data; cfg_ready is tied
// high, so a config beat lands on any edge with cfg_valid high.
// Throughput: one beat per cycle while the receiver keeps popping, set by the
// bit-per-stage divider pipeline. A beat passes the four-entry front queue,
// one multiply stage, one sum stage, VEL_WIDTH divide stages and the
// output register. When the receiver stalls the whole back pipeline holds;
// the front queue keeps taking beats until its four entries are full, then
// raises full.
// Reset (rst_n low, synchronous) empties the queue and pipeline and loads
// threshold 0.5 and wall-flow mode off.
module small_cell_velocity_correction #(
  parameter int VEL_WIDTH = scvc_pkg::VEL_WIDTH_DEF,
  parameter int FRAC_BITS = scvc_pkg::FRAC_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        push,
  output logic                        full,
  input  logic [1:0]                  in_axis,
  input  logic [FRAC_BITS:0]          in_volume_fraction,
  input  logic [FRAC_BITS:0]          in_area_low,
  input  logic [FRAC_BITS:0]          in_area_high,
  input  logic signed [VEL_WIDTH-1:0] in_face_vel_low,
  input  logic signed [VEL_WIDTH-1:0] in_face_vel_high,
  input  logic signed [VEL_WIDTH-1:0] in_old_velocity,
  input  logic signed [VEL_WIDTH-1:0] in_wall_vel_x,
  input  logic signed [VEL_WIDTH-1:0] in_wall_vel_y,
  input  logic signed [VEL_WIDTH-1:0] in_wall_vel_z,
  output logic                        empty,
  input  logic                        pop,
  output logic signed [VEL_WIDTH-1:0] out_new_velocity,
  output logic                        out_corrected,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic                        cfg_index,
  input  logic [FRAC_BITS:0]          cfg_data
);
  import scvc_pkg::*;

  localparam int FW = FRAC_BITS + 1;
  localparam int EW = CLS_WIDTH + 2 * FW + 3 * VEL_WIDTH;
  // one half in Q1.FRAC_BITS
  localparam logic [FW-1:0] THRESH_RESET = {2'b01, {(FW-2){1'b0}}};

  // config registers
  logic [FW-1:0] thresh_r;
  logic          wall_mode_r;

  // front to queue
  cls_t                 fr_cls;
  logic [VEL_WIDTH-1:0] fr_byp;
  logic [EW-1:0]        q_wdata;

  // queue to back
  logic [EW-1:0]        q_rdata;
  logic                 q_empty;
  logic                 q_pop;
  cls_t                 rd_cls;
  logic [FW-1:0]        rd_al, rd_ah;
  logic [VEL_WIDTH-1:0] rd_fl, rd_fh, rd_byp;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thresh_r    <= THRESH_RESET;
      wall_mode_r <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_THRESHOLD: thresh_r    <= cfg_data;
        CFG_WALL_MODE: wall_mode_r <= cfg_data[0];
      endcase
    end
  end

  // classify and settle every case that needs no divide
  scvc_front #(
    .VEL_WIDTH (VEL_WIDTH),
    .FRAC_BITS (FRAC_BITS)
  ) u_front (
    .axis            (in_axis),
    .volume_fraction (in_volume_fraction),
    .area_low        (in_area_low),
    .area_high       (in_area_high),
    .old_velocity    (in_old_velocity),
    .wall_vel_x      (in_wall_vel_x),
    .wall_vel_y      (in_wall_vel_y),
    .wall_vel_z      (in_wall_vel_z),
    .threshold       (thresh_r),
    .wall_mode       (wall_mode_r),
    .cls             (fr_cls),
    .byp_vel         (fr_byp)
  );

  assign q_wdata = {fr_cls, in_area_low, in_area_high,
                    in_face_vel_low, in_face_vel_high, fr_byp};

  scvc_queue #(
    .WIDTH (EW)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .wdata (q_wdata),
    .full  (full),
    .pop   (q_pop),
    .rdata (q_rdata),
    .empty (q_empty)
  );

  assign {rd_cls, rd_al, rd_ah, rd_fl, rd_fh, rd_byp} = q_rdata;

  // weighted average through the divide pipeline
  scvc_back #(
    .VEL_WIDTH (VEL_WIDTH),
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (!q_empty),
    .in_cls           (rd_cls),
    .in_area_low      (rd_al),
    .in_area_high     (rd_ah),
    .in_face_vel_low  (rd_fl),
    .in_face_vel_high (rd_fh),
    .in_byp_vel       (rd_byp),
    .in_pop           (q_pop),
    .out_empty        (empty),
    .out_pop          (pop),
    .out_new_velocity (out_new_velocity),
    .out_corrected    (out_corrected)
  );

endmodule

>>> tb/sv/tb_small_cell_velocity_correction.sv
`timescale 1ns / 1ps
// Self-checking bench for the small-cell velocity correction block: directed and random cells.
module tb_small_cell_velocity_correction;

  import scvc_pkg::*;

  localparam int VW = VEL_WIDTH_DEF;
  localparam int FW = FRAC_BITS_DEF;
  localparam logic [1:0] AXIS_Z     = 2'd2;
  localparam logic [1:0] AXIS_SPARE = 2'd3;     // unused code, behaves as z
  localparam logic [FW:0] FRAC_ONE  = 17'd65536;
  localparam logic [FW:0] THR_RESET = 17'd32768;
  localparam logic signed [VW-1:0] VEL_MAX = {1'b0, {(VW-1){1'b1}}};
  localparam logic signed [VW-1:0] VEL_MIN = {1'b1, {(VW-1){1'b0}}};
  localparam int LIMIT_CYCLES = 400000;
  localparam int TAIL_CYCLES  = 40;
  localparam int PRINT_CAP    = 50;

  typedef enum logic [1:0] {
    IDLE_NONE,
    IDLE_SENDER,
    IDLE_RECEIVER,
    IDLE_BOTH
  } idle_mode_t;

  // One input beat: one cell, one axis.
  typedef struct {
    logic [1:0]             axis;
    logic [FW:0]            volume_fraction;
    logic [FW:0]            area_low;
    logic [FW:0]            area_high;
    logic signed [VW-1:0]   face_vel_low;
    logic signed [VW-1:0]   face_vel_high;
    logic signed [VW-1:0]   old_velocity;
    logic signed [VW-1:0]   wall_vel_x;
    logic signed [VW-1:0]   wall_vel_y;
    logic signed [VW-1:0]   wall_vel_z;
  } cell_beat_t;

  typedef struct {
    logic signed [VW-1:0] new_velocity;
    logic                 corrected;
  } velocity_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic push = 1'b0;
  logic full;
  logic [1:0] in_axis = '0;
  logic [FW:0] in_volume_fraction = '0;
  logic [FW:0] in_area_low = '0;
  logic [FW:0] in_area_high = '0;
  logic signed [VW-1:0] in_face_vel_low = '0;
  logic signed [VW-1:0] in_face_vel_high = '0;
  logic signed [VW-1:0] in_old_velocity = '0;
  logic signed [VW-1:0] in_wall_vel_x = '0;
  logic signed [VW-1:0] in_wall_vel_y = '0;
  logic signed [VW-1:0] in_wall_vel_z = '0;
  logic empty;
  logic pop = 1'b0;
  logic signed [VW-1:0] out_new_velocity;
  logic out_corrected;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic cfg_index = CFG_THRESHOLD;
  logic [FW:0] cfg_data = '0;

  // Shadow copy of the block's registers, as last written.
  logic [FW:0] threshold_q = THR_RESET;
  logic        wall_mode_q = 1'b0;

  cell_beat_t       cell_queue[$];           // cells waiting to be pushed
  velocity_result_t expected_velocities[$];  // predictions awaiting their beat
  idle_mode_t       idle_mode = IDLE_NONE;
  int               mismatch_count = 0;
  int               cycle_count = 0;

  small_cell_velocity_correction uut (
    .clk                (clk),
    .rst_n              (rst_n),
    .push               (push),
    .full               (full),
    .in_axis            (in_axis),
    .in_volume_fraction (in_volume_fraction),
    .in_area_low        (in_area_low),
    .in_area_high       (in_area_high),
    .in_face_vel_low    (in_face_vel_low),
    .in_face_vel_high   (in_face_vel_high),
    .in_old_velocity    (in_old_velocity),
    .in_wall_vel_x      (in_wall_vel_x),
    .in_wall_vel_y      (in_wall_vel_y),
    .in_wall_vel_z      (in_wall_vel_z),
    .empty              (empty),
    .pop                (pop),
    .out_new_velocity   (out_new_velocity),
    .out_corrected      (out_corrected),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data)
  );

  // 12 ns period, rising edge at time zero.
  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  // Predicted output for one cell under the current register settings.
  // Weighted average is done in 64-bit signed arithmetic; SV division
  // truncates toward zero, which is what the block must do.
  function automatic velocity_result_t predict_velocity(cell_beat_t c);
    velocity_result_t r;
    longint old_v, wall, num, den, vel;
    old_v = longint'(c.old_velocity);
    case (c.axis)
      AXIS_X:  wall = longint'(c.wall_vel_x);
      AXIS_Y:  wall = longint'(c.wall_vel_y);
      default: wall = longint'(c.wall_vel_z);   // z and the spare code
    endcase
    vel = old_v;
    r.corrected = 1'b0;
    if (c.volume_fraction != '0 && c.volume_fraction < threshold_q) begin
      r.corrected = 1'b1;
      den = longint'(c.area_low) + longint'(c.area_high);
      if (den == 0) begin
        vel = 0;
      end else begin
        num = longint'(c.area_low) * longint'(c.face_vel_low)
            + longint'(c.area_high) * longint'(c.face_vel_high);
        vel = num / den;
      end
      // Moving wall on this axis: clamp old velocity against it.
      if (wall_mode_q) begin
        if (wall > 0) begin
          vel = (old_v < wall) ? old_v : wall;
        end else if (wall < 0) begin
          vel = (old_v > wall) ? old_v : wall;
        end
      end
    end
    r.new_velocity = vel[VW-1:0];
    return r;
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    if (mismatch_count < PRINT_CAP)
      $display("%0t: %s mismatch, got %0d expected %0d", $time, what, got, want);
    mismatch_count++;
  endtask

  function automatic logic sender_idles();
    case (idle_mode)
      IDLE_SENDER: return $urandom_range(0, 99) < 84;
      IDLE_BOTH:   return $urandom_range(0, 99) < 12;
      default:     return 1'b0;
    endcase
  endfunction

  function automatic logic receiver_stalls();
    case (idle_mode)
      IDLE_RECEIVER: return $urandom_range(0, 99) < 84;
      IDLE_BOTH:     return $urandom_range(0, 99) < 12;
      default:       return 1'b0;
    endcase
  endfunction

  // Driver: everything changes on the falling edge. The head of cell_queue
  // is offered until the monitor sees it taken.
  always @(negedge clk) begin
    if (!rst_n) begin
      push <= 1'b0;
      pop  <= 1'b0;
    end else begin
      if (cell_queue.size() != 0 && !sender_idles()) begin
        push               <= 1'b1;
        in_axis            <= cell_queue[0].axis;
        in_volume_fraction <= cell_queue[0].volume_fraction;
        in_area_low        <= cell_queue[0].area_low;
        in_area_high       <= cell_queue[0].area_high;
        in_face_vel_low    <= cell_queue[0].face_vel_low;
        in_face_vel_high   <= cell_queue[0].face_vel_high;
        in_old_velocity    <= cell_queue[0].old_velocity;
        in_wall_vel_x      <= cell_queue[0].wall_vel_x;
        in_wall_vel_y      <= cell_queue[0].wall_vel_y;
        in_wall_vel_z      <= cell_queue[0].wall_vel_z;
      end else begin
        push <= 1'b0;
      end
      pop <= !receiver_stalls();
    end
  end

  // Monitor: samples both channels on the rising edge. An input beat turns
  // into a prediction; a result beat is checked against the oldest one.
  always @(posedge clk) begin
    velocity_result_t want;
    if (rst_n) begin
      if (push && !full && cell_queue.size() != 0)
        expected_velocities.push_back(predict_velocity(cell_queue.pop_front()));
      if (pop && !empty) begin
        if (expected_velocities.size() == 0) begin
          report_mismatch("unexpected result beat", out_new_velocity, 0);
        end else begin
          want = expected_velocities.pop_front();
          if (out_new_velocity !== want.new_velocity)
            report_mismatch("new_velocity", out_new_velocity, want.new_velocity);
          if (out_corrected !== want.corrected)
            report_mismatch("corrected", out_corrected, want.corrected);
        end
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == LIMIT_CYCLES) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Leaves cfg_valid high; the caller drops it after its last write.
  task automatic cfg_write(input logic idx, input logic [FW:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    if (idx == CFG_THRESHOLD)
      threshold_q = data;
    else
      wall_mode_q = data[0];
  endtask

  task automatic set_config(input logic [FW:0] thr, input logic wall_mode);
    cfg_write(CFG_THRESHOLD, thr);
    cfg_write(CFG_WALL_MODE, {{FW{1'b0}}, wall_mode});
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic queue_cell(input logic [1:0] axis, input logic [FW:0] vf,
                            input logic [FW:0] al, input logic [FW:0] ah,
                            input logic signed [VW-1:0] fl,
                            input logic signed [VW-1:0] fh,
                            input logic signed [VW-1:0] old_v,
                            input logic signed [VW-1:0] wx,
                            input logic signed [VW-1:0] wy,
                            input logic signed [VW-1:0] wz);
    cell_beat_t c;
    c.axis = axis;
    c.volume_fraction = vf;
    c.area_low = al;
    c.area_high = ah;
    c.face_vel_low = fl;
    c.face_vel_high = fh;
    c.old_velocity = old_v;
    c.wall_vel_x = wx;
    c.wall_vel_y = wy;
    c.wall_vel_z = wz;
    cell_queue.push_back(c);
  endtask

  function automatic logic signed [VW-1:0] rand_vel();
    case ($urandom_range(0, 9))
      0:       return VEL_MAX;
      1:       return VEL_MIN;
      2:       return '0;
      3:       return '1;
      default: return VW'($urandom());
    endcase
  endfunction

  // Zero nearly half the time so the "this axis still" case stays common.
  function automatic logic signed [VW-1:0] rand_wall();
    if ($urandom_range(0, 9) < 4)
      return '0;
    return rand_vel();
  endfunction

  // Fractions, including values above one and all ones.
  function automatic logic [FW:0] rand_frac();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return FRAC_ONE;
      2:       return '1;
      3:       return (FW+1)'($urandom());
      default: return (FW+1)'($urandom_range(1, 65535));
    endcase
  endfunction

  task automatic queue_random_cell();
    logic [FW:0] vf, al, ah;
    case ($urandom_range(0, 9))
      0:       vf = '0;
      1:       vf = rand_frac();
      default: vf = (FW+1)'($urandom_range(1, 65535));   // usually in range
    endcase
    if ($urandom_range(0, 9) == 0) begin
      al = '0;
      ah = '0;
    end else begin
      al = rand_frac();
      ah = rand_frac();
    end
    queue_cell(2'($urandom_range(0, 3)), vf, al, ah, rand_vel(), rand_vel(), rand_vel(),
               rand_wall(), rand_wall(), rand_wall());
  endtask

  task automatic wait_drained();
    while (cell_queue.size() != 0 || expected_velocities.size() != 0)
      @(negedge clk);
  endtask

  task automatic run_random(input idle_mode_t mode, input int count);
    @(negedge clk);
    idle_mode = mode;
    repeat (count) queue_random_cell();
    wait_drained();
  endtask

  initial begin
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;

    // Directed cells at reset settings: threshold one half, no wall clamp.
    @(negedge clk);
    // volume zero: passes through
    queue_cell(AXIS_X, '0, FRAC_ONE, FRAC_ONE, VEL_MIN, VEL_MAX, VEL_MAX, '0, '0, '0);
    // just under threshold, face velocity extremes
    queue_cell(AXIS_X, 17'd32767, FRAC_ONE, FRAC_ONE, VEL_MAX, VEL_MIN, '0, '0, '0, '0);
    // equal to threshold: not corrected
    queue_cell(AXIS_Y, THR_RESET, FRAC_ONE, '0, VEL_MAX, '0, VEL_MIN, '0, '0, '0);
    // both areas zero: result is zero
    queue_cell(AXIS_Z, 17'd1, '0, '0, VEL_MAX, VEL_MAX, VEL_MAX, '0, '0, '0);
    // only upper face open
    queue_cell(AXIS_X, 17'd1, '0, FRAC_ONE, VEL_MAX, VEL_MIN, 24'sd5, '0, '0, '0);
    // fractions above one, negative average rounds toward zero
    queue_cell(AXIS_Y, 17'd100, '1, '1, -24'sd1, -24'sd2, '0, '0, '0, '0);
    // small negative quotient with remainder goes to zero
    queue_cell(AXIS_Z, 17'd200, 17'd1, 17'd2, -24'sd1, '0, 24'sd9, '0, '0, '0);
    queue_cell(AXIS_X, 17'd300, 17'd1, 17'd2, 24'sd1, '0, -24'sd9, '0, '0, '0);
    // volume above one: passes through
    queue_cell(AXIS_Y, '1, FRAC_ONE, FRAC_ONE, 24'sd7, 24'sd7, -24'sd3, '0, '0, '0);
    // spare axis code
    queue_cell(AXIS_SPARE, 17'd10, 17'd12345, 17'd54321, 24'sd4096, -24'sd8192, '0,
               '0, '0, '0);
    wait_drained();

    // Wall clamp on, threshold unchanged.
    set_config(THR_RESET, 1'b1);
    queue_cell(AXIS_X, 17'd50, FRAC_ONE, FRAC_ONE, '0, '0, 24'sd500, 24'sd100, '0, '0);
    queue_cell(AXIS_Y, 17'd50, FRAC_ONE, FRAC_ONE, '0, '0, -24'sd500, '0, -24'sd100, '0);
    queue_cell(AXIS_Z, 17'd50, FRAC_ONE, FRAC_ONE, '0, '0, 24'sd20, '0, '0, 24'sd100);
    queue_cell(AXIS_SPARE, 17'd50, FRAC_ONE, '0, '0, '0, 24'sd20, '0, '0, -24'sd100);
    // still wall on this axis, others moving: average kept; then moving walls at the extremes
    queue_cell(AXIS_X, 17'd50, 17'd3, 17'd5, 24'sd800, -24'sd800, '0, '0, VEL_MAX, VEL_MIN);
    queue_cell(AXIS_Y, 17'd50, FRAC_ONE, FRAC_ONE, '0, '0, VEL_MIN, '0, VEL_MAX, '0);
    queue_cell(AXIS_Z, 17'd50, FRAC_ONE, FRAC_ONE, '0, '0, VEL_MAX, '0, '0, VEL_MIN);
    // outside range: wall ignored
    queue_cell(AXIS_X, '0, FRAC_ONE, FRAC_ONE, '0, '0, 24'sd77, 24'sd1, '0, '0);
    queue_cell(AXIS_X, THR_RESET, FRAC_ONE, FRAC_ONE, '0, '0, 24'sd77, 24'sd1, '0, '0);
    // both areas zero, moving wall
    queue_cell(AXIS_Y, 17'd1, '0, '0, '0, '0, -24'sd77, '0, -24'sd1, '0);
    wait_drained();

    // Random phases across register settings and idle patterns.
    set_config(FRAC_ONE, 1'b1);
    run_random(IDLE_NONE, 450);
    set_config(FRAC_ONE, 1'b0);
    run_random(IDLE_SENDER, 450);
    set_config((FW+1)'($urandom_range(0, 65536)), 1'b1);
    run_random(IDLE_RECEIVER, 450);
    set_config('0, 1'b1);
    run_random(IDLE_BOTH, 100);
    set_config(17'd40000, 1'b0);
    run_random(IDLE_BOTH, 400);

    // Let anything stray fall out of the pipeline before judging.
    @(negedge clk);
    idle_mode = IDLE_NONE;
    repeat (TAIL_CYCLES) @(negedge clk);
    if (expected_velocities.size() != 0)
      mismatch_count++;
    if (mismatch_count == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule

>>> sim.f
+incdir+rtl
rtl/scvc_pkg.sv
rtl/scvc_front.sv
rtl/scvc_queue.sv
rtl/scvc_back.sv
rtl/small_cell_velocity_correction.sv
tb/sv/tb_small_cell_velocity_correction.sv
